### hdl/ip_address_text_classifier_assert.svh
// Assertion macros shared by the classifier modules.
`ifndef IP_ADDRESS_TEXT_CLASSIFIER_ASSERT_SVH
`define IP_ADDRESS_TEXT_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IPATC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ipatc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define IPATC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ipatc: next-cycle check failed");

`endif

### hdl/ipatc_pkg.sv
package ipatc_pkg;

    // Character codes.
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // Dotted-quad limits.
    localparam logic [1:0] QUAD_LAST_SEP   = 2'd3;
    localparam logic [1:0] QUAD_MAX_DIGITS = 2'd3;
    localparam logic [9:0] QUAD_MAX_VALUE  = 10'd255;

    // Colon-field limits.
    localparam logic [2:0] HEX_LAST_SEP   = 3'd7;
    localparam logic [2:0] HEX_MAX_DIGITS = 3'd4;

    typedef enum logic [2:0] {
        K_DOT,
        K_COLON,
        K_DEC,
        K_HEX_ALPHA,
        K_OTHER
    } t_kind;

    typedef enum logic [1:0] {
        CLASS_NONE = 2'd0,
        CLASS_V4   = 2'd1,
        CLASS_V6   = 2'd2
    } t_class;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] digit;
        logic       last;
    } t_token;

    // Reduce one character byte to the token the checkers need.
    function automatic t_token classify(input logic [7:0] c, input logic last);
        t_token tok;
        tok.kind  = K_OTHER;
        tok.digit = c[3:0];
        tok.last  = last;
        case (c) inside
            CH_DOT:                       tok.kind = K_DOT;
            CH_COLON:                     tok.kind = K_COLON;
            [8'h30:8'h39]:                tok.kind = K_DEC;
            [8'h41:8'h46], [8'h61:8'h66]: tok.kind = K_HEX_ALPHA;
            default:                      tok.kind = K_OTHER;
        endcase
        return tok;
    endfunction

endpackage

### hdl/ip_address_text_classifier.sv
// The class of a string is on o_address_class, with empty low, once its last
//   character has passed the front stage and then the token queue (the checkers
//   write the result queue in the cycle they pop the token).
// Throughput: one character per cycle, except while full stalls the input.
// Reset: i_rst_n is synchronous and active low; it empties both queues and returns
//   both checkers to a clean start.
module ip_address_text_classifier #(
    parameter int TOKEN_DEPTH  = 4,
    parameter int RESULT_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_char_code,
    input  logic       i_is_last,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_address_class
);

    localparam int TOKEN_W = $bits(ipatc_pkg::t_token);

    ipatc_pkg::t_token w_front_token;
    ipatc_pkg::t_token w_back_token;
    logic              w_front_valid;
    logic              w_tq_full;
    logic              w_tq_empty;
    logic              w_tq_pop;
    logic              w_rq_push;
    logic              w_rq_full;
    logic [1:0]        w_result;

    // Front end: classify each transferred character into a small token
    // (separator kind, hex/decimal digit, digit value, last flag) and stage it
    // in one register. The input side stalls only when that stage is full and
    // the token queue cannot take it.
    ipatc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_char_code   (i_char_code),
        .i_is_last     (i_is_last),
        .o_full        (full),
        .o_token_valid (w_front_valid),
        .o_token       (w_front_token),
        .i_token_full  (w_tq_full)
    );

    // Token queue: decouples classification from the checkers so a stalled
    // result side does not immediately stop the character stream.
    ipatc_fifo #(
        .WIDTH (TOKEN_W),
        .DEPTH (TOKEN_DEPTH)
    ) u_token_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .i_data  (w_front_token),
        .o_full  (w_tq_full),
        .i_pop   (w_tq_pop),
        .o_data  (w_back_token),
        .o_empty (w_tq_empty)
    );

    // Back end: dotted-quad and colon checkers advance side by side on every
    // token; a last token emits the class and restarts both checkers.
    ipatc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_token_valid (!w_tq_empty),
        .i_token       (w_back_token),
        .o_token_pop   (w_tq_pop),
        .o_result_push (w_rq_push),
        .o_result      (w_result),
        .i_result_full (w_rq_full)
    );

    // Result queue: holds finished classes until the consumer pops them, so
    // the checkers keep going while a result waits.
    ipatc_fifo #(
        .WIDTH (2),
        .DEPTH (RESULT_DEPTH)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_rq_push),
        .i_data  (w_result),
        .o_full  (w_rq_full),
        .i_pop   (pop),
        .o_data  (o_address_class),
        .o_empty (empty)
    );

endmodule

### hdl/ipatc_fifo.sv
`include "ip_address_text_classifier_assert.svh"

module ipatc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_count, n_count;
    logic             w_wr_en;
    logic             w_rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign w_wr_en = i_push && !o_full;
    assign w_rd_en = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_wr_en) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_rd_en) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({w_wr_en, w_rd_en})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `IPATC_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))
    `IPATC_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, w_wr_en && !w_rd_en, r_count == $past(r_count) + 1'b1)

endmodule

### hdl/ipatc_front.sv
module ipatc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [7:0]          i_char_code,
    input  logic                i_is_last,
    output logic                o_full,
    output logic                o_token_valid,
    output ipatc_pkg::t_token   o_token,
    input  logic                i_token_full
);

    logic              r_valid;
    ipatc_pkg::t_token r_token;
    logic              w_accept;
    logic              w_drain;

    // Hold the staged token until the queue takes it.
    assign w_drain       = r_valid && !i_token_full;
    assign o_full        = r_valid && i_token_full;
    assign w_accept      = i_push && !o_full;
    assign o_token_valid = r_valid;
    assign o_token       = r_token;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (w_drain) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_token <= ipatc_pkg::classify(i_char_code, i_is_last);
        end
    end

endmodule

### hdl/ipatc_back.sv
`include "ip_address_text_classifier_assert.svh"

module ipatc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_token_valid,
    input  ipatc_pkg::t_token i_token,
    output logic              o_token_pop,
    output logic              o_result_push,
    output logic [1:0]        o_result,
    input  logic              i_result_full
);

    logic       r_quad_ok,  n_quad_ok;
    logic [1:0] r_quad_sep, n_quad_sep;
    logic [1:0] r_quad_len, n_quad_len;
    logic [9:0] r_quad_val, n_quad_val;
    logic       r_quad_lz,  n_quad_lz;
    logic       r_hex_ok,   n_hex_ok;
    logic [2:0] r_hex_sep,  n_hex_sep;
    logic [2:0] r_hex_len,  n_hex_len;
    logic [9:0] w_val_next;
    logic       w_v4;
    logic       w_v6;
    logic       w_done;

    // A last token waits for room in the result queue; others never stall.
    assign o_token_pop   = i_token_valid && (!i_token.last || !i_result_full);
    assign w_done        = o_token_pop && i_token.last;
    assign o_result_push = w_done;

    // value * 10 + digit, kept to ten bits
    assign w_val_next = {r_quad_val[6:0], 3'b000} + {r_quad_val[8:0], 1'b0}
                        + {6'd0, i_token.digit};

    always_comb begin
        n_quad_ok  = r_quad_ok;
        n_quad_sep = r_quad_sep;
        n_quad_len = r_quad_len;
        n_quad_val = r_quad_val;
        n_quad_lz  = r_quad_lz;
        n_hex_ok   = r_hex_ok;
        n_hex_sep  = r_hex_sep;
        n_hex_len  = r_hex_len;

        if (o_token_pop && r_quad_ok) begin
            case (i_token.kind)
                ipatc_pkg::K_DOT: begin
                    if (r_quad_len == '0 || r_quad_sep >= ipatc_pkg::QUAD_LAST_SEP) begin
                        n_quad_ok = 1'b0;
                    end else begin
                        n_quad_sep = r_quad_sep + 1'b1;
                        n_quad_len = '0;
                        n_quad_val = '0;
                        n_quad_lz  = 1'b0;
                    end
                end
                ipatc_pkg::K_DEC: begin
                    if (r_quad_len >= ipatc_pkg::QUAD_MAX_DIGITS) begin
                        n_quad_ok = 1'b0;
                    end else if (r_quad_len != '0 && r_quad_lz) begin
                        n_quad_ok = 1'b0;
                    end else begin
                        if (r_quad_len == '0) begin
                            n_quad_lz = (i_token.digit == 4'd0);
                        end
                        n_quad_val = w_val_next;
                        n_quad_len = r_quad_len + 1'b1;
                        if (w_val_next > ipatc_pkg::QUAD_MAX_VALUE) begin
                            n_quad_ok = 1'b0;
                        end
                    end
                end
                default: n_quad_ok = 1'b0;
            endcase
        end

        if (o_token_pop && r_hex_ok) begin
            case (i_token.kind)
                ipatc_pkg::K_COLON: begin
                    if (r_hex_len == '0 || r_hex_sep >= ipatc_pkg::HEX_LAST_SEP) begin
                        n_hex_ok = 1'b0;
                    end else begin
                        n_hex_sep = r_hex_sep + 1'b1;
                        n_hex_len = '0;
                    end
                end
                ipatc_pkg::K_DEC, ipatc_pkg::K_HEX_ALPHA: begin
                    if (r_hex_len >= ipatc_pkg::HEX_MAX_DIGITS) begin
                        n_hex_ok = 1'b0;
                    end else begin
                        n_hex_len = r_hex_len + 1'b1;
                    end
                end
                default: n_hex_ok = 1'b0;
            endcase
        end

        w_v4 = n_quad_ok && n_quad_sep == ipatc_pkg::QUAD_LAST_SEP && n_quad_len != '0;
        w_v6 = n_hex_ok && n_hex_sep == ipatc_pkg::HEX_LAST_SEP && n_hex_len != '0;
        if (w_v4) begin
            o_result = ipatc_pkg::CLASS_V4;
        end else if (w_v6) begin
            o_result = ipatc_pkg::CLASS_V6;
        end else begin
            o_result = ipatc_pkg::CLASS_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_done) begin
            r_quad_ok  <= 1'b1;
            r_quad_sep <= '0;
            r_quad_len <= '0;
            r_quad_val <= '0;
            r_quad_lz  <= 1'b0;
            r_hex_ok   <= 1'b1;
            r_hex_sep  <= '0;
            r_hex_len  <= '0;
        end else begin
            r_quad_ok  <= n_quad_ok;
            r_quad_sep <= n_quad_sep;
            r_quad_len <= n_quad_len;
            r_quad_val <= n_quad_val;
            r_quad_lz  <= n_quad_lz;
            r_hex_ok   <= n_hex_ok;
            r_hex_sep  <= n_hex_sep;
            r_hex_len  <= n_hex_len;
        end
    end

    `IPATC_ASSERT_NEXT(a_fresh_after_last, i_clk, i_rst_n, w_done, r_quad_ok && r_hex_ok && r_quad_sep == '0 && r_hex_sep == '0)
    `IPATC_ASSERT_NEXT(a_quad_fail_holds, i_clk, i_rst_n, !r_quad_ok && !w_done, !r_quad_ok && $stable(r_quad_sep) && $stable(r_quad_len))

endmodule

### sim/tb_ip_address_text_classifier.sv
`timescale 1ns / 100ps

module tb_ip_address_text_classifier;

    typedef logic [7:0] t_text[$];

    // Expected-class tracker: mirrors both address checkers and keeps the
    // classes still owed by the block, oldest first.
    class addr_class_scoreboard;
        bit                 quad_ok;
        logic [1:0]         quad_seps;
        logic [1:0]         quad_len;
        logic [9:0]         quad_val;
        bit                 quad_lz;
        bit                 hex_ok;
        logic [2:0]         hex_seps;
        logic [2:0]         hex_len;
        ipatc_pkg::t_class  owed_classes[$];
        int                 fail_count;

        function new();
            fail_count = 0;
            clear_checkers();
        endfunction

        function void clear_checkers();
            quad_ok   = 1'b1;
            quad_seps = '0;
            quad_len  = '0;
            quad_val  = '0;
            quad_lz   = 1'b0;
            hex_ok    = 1'b1;
            hex_seps  = '0;
            hex_len   = '0;
        endfunction

        function void dotted_step(logic [7:0] c);
            if (!quad_ok)
                return;
            if (c == ipatc_pkg::CH_DOT) begin
                if (quad_len == 0 || quad_seps >= ipatc_pkg::QUAD_LAST_SEP) begin
                    quad_ok = 1'b0;
                end else begin
                    quad_seps = quad_seps + 2'd1;
                    quad_len  = '0;
                    quad_val  = '0;
                    quad_lz   = 1'b0;
                end
            end else if (c >= "0" && c <= "9") begin
                if (quad_len >= ipatc_pkg::QUAD_MAX_DIGITS || (quad_len >= 1 && quad_lz)) begin
                    quad_ok = 1'b0;
                end else begin
                    if (quad_len == 0)
                        quad_lz = (c == "0");
                    quad_val = 10'(quad_val * 10'd10 + 10'(c - "0"));
                    quad_len = quad_len + 2'd1;
                    if (quad_val > ipatc_pkg::QUAD_MAX_VALUE)
                        quad_ok = 1'b0;
                end
            end else begin
                quad_ok = 1'b0;
            end
        endfunction

        function void colon_step(logic [7:0] c);
            bit hex_digit;
            if (!hex_ok)
                return;
            hex_digit = (c >= "0" && c <= "9") || (c >= "a" && c <= "f")
                        || (c >= "A" && c <= "F");
            if (c == ipatc_pkg::CH_COLON) begin
                if (hex_len == 0 || hex_seps >= ipatc_pkg::HEX_LAST_SEP) begin
                    hex_ok = 1'b0;
                end else begin
                    hex_seps = hex_seps + 3'd1;
                    hex_len  = '0;
                end
            end else if (hex_digit) begin
                if (hex_len >= ipatc_pkg::HEX_MAX_DIGITS)
                    hex_ok = 1'b0;
                else
                    hex_len = hex_len + 3'd1;
            end else begin
                hex_ok = 1'b0;
            end
        endfunction

        // Note one transferred character; the final one owes a class.
        function void take_char(logic [7:0] c, logic last);
            bit                v4;
            bit                v6;
            ipatc_pkg::t_class cls;
            dotted_step(c);
            colon_step(c);
            if (!last)
                return;
            v4 = quad_ok && quad_seps == ipatc_pkg::QUAD_LAST_SEP && quad_len >= 1;
            v6 = hex_ok && hex_seps == ipatc_pkg::HEX_LAST_SEP && hex_len >= 1;
            if (v4)
                cls = ipatc_pkg::CLASS_V4;
            else if (v6)
                cls = ipatc_pkg::CLASS_V6;
            else
                cls = ipatc_pkg::CLASS_NONE;
            owed_classes = {owed_classes, cls};
            clear_checkers();
        endfunction

        function void check_class(logic [1:0] actual);
            ipatc_pkg::t_class want;
            if (owed_classes.size() == 0) begin
                $display("%0t: address_class expected none actual %0d", $time, actual);
                fail_count++;
                return;
            end
            want = owed_classes.pop_front();
            if (actual !== want) begin
                $display("%0t: address_class expected %0d actual %0d",
                         $time, want, actual);
                fail_count++;
            end
        endfunction

        function int pending();
            return owed_classes.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [7:0] i_char_code;
    logic       i_is_last;
    logic       empty;
    logic       pop;
    logic [1:0] o_address_class;

    addr_class_scoreboard sb;
    int  chars_sent;
    int  strings_sent;
    int  results_seen;
    int  hold_left;
    bit  hold_done;
    bit  quiet_sender;

    ip_address_text_classifier uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_char_code    (i_char_code),
        .i_is_last      (i_is_last),
        .empty          (empty),
        .pop            (pop),
        .o_address_class(o_address_class)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("[ip_address_text_classifier] ERROR");
        $finish;
    end

    // Offer one character and hold it until a transfer; idle first at random
    // unless the quiet stretch is on.
    task automatic send_char(input logic [7:0] c, input logic last);
        while (!quiet_sender && $urandom_range(0, 99) < 16) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push        <= 1'b1;
        i_char_code <= c;
        i_is_last   <= last;
        do
            @(posedge i_clk);
        while (full);
        sb.take_char(c, last);
        chars_sent++;
    endtask

    task automatic send_text(input t_text q);
        for (int k = 0; k < q.size(); k++)
            send_char(q[k], k == q.size() - 1);
        strings_sent++;
    endtask

    task automatic send_str(input string s);
        t_text q;
        q = {};
        for (int k = 0; k < s.len(); k++)
            q = {q, 8'(s[k])};
        send_text(q);
    endtask

    // Drop push and wait for every owed class to come back.
    task automatic drain();
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    function automatic void append_str(ref t_text q, input string s);
        for (int k = 0; k < s.len(); k++)
            q = {q, 8'(s[k])};
    endfunction

    // Dotted quad with random field values; wide allows values up to 999.
    function automatic t_text make_quad(bit wide);
        t_text q;
        q = {};
        for (int f = 0; f < 4; f++) begin
            if (f != 0)
                q = {q, ipatc_pkg::CH_DOT};
            append_str(q, $sformatf("%0d", $urandom_range(0, wide ? 999 : 255)));
        end
        return q;
    endfunction

    // Eight colon fields of one to four hex digits in mixed case.
    function automatic t_text make_colon();
        t_text q;
        int    v;
        q = {};
        for (int f = 0; f < 8; f++) begin
            if (f != 0)
                q = {q, ipatc_pkg::CH_COLON};
            repeat ($urandom_range(1, 4)) begin
                v = $urandom_range(0, 15);
                if (v < 10)
                    q = {q, 8'("0" + v)};
                else
                    q = {q, 8'(($urandom_range(0, 1) ? "A" : "a") + v - 10)};
            end
        end
        return q;
    endfunction

    function automatic logic [7:0] pick_char();
        string alphabet;
        alphabet = "0123456789abcdefABCDEF.:";
        if ($urandom_range(0, 1))
            return 8'($urandom_range(0, 255));
        return alphabet[$urandom_range(0, alphabet.len() - 1)];
    endfunction

    // Alter a string in one of several ways that usually break a well-formed one.
    function automatic void mutate_text(ref t_text q);
        int pos;
        pos = $urandom_range(0, q.size() - 1);
        case ($urandom_range(0, 7))
            0: q[pos] = 8'($urandom_range(0, 255));
            1: if (q.size() > 1) q.delete(pos);
            2: q.insert(pos, pick_char());
            3: q[pos] = $urandom_range(0, 1) ? ipatc_pkg::CH_DOT : ipatc_pkg::CH_COLON;
            4: begin
                q = {q, ($urandom_range(0, 1) ? ipatc_pkg::CH_DOT : ipatc_pkg::CH_COLON)};
                q = {q, 8'("7")};
            end
            5: q.insert(0, "0");
            6: q.insert(pos, 8'("0" + $urandom_range(0, 9)));
            default: q = q[0:pos];
        endcase
    endfunction

    function automatic t_text make_noise();
        t_text q;
        q = {};
        repeat ($urandom_range(1, 20))
            q = {q, pick_char()};
        return q;
    endfunction

    // Receiver: check each transfer, then choose pop for the next edge.
    initial begin
        pop          <= 1'b0;
        results_seen = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (pop && !empty) begin
                    sb.check_class(o_address_class);
                    results_seen++;
                end
                if (hold_left > 0) begin
                    // Long hold-off: let the block fill up and stall its input.
                    hold_left--;
                    pop <= 1'b0;
                end else if (results_seen == 25 && !hold_done) begin
                    hold_done = 1'b1;
                    hold_left = 150;
                    pop <= 1'b0;
                end else if (results_seen >= 50 && results_seen < 75) begin
                    pop <= 1'b1;
                end else begin
                    pop <= ($urandom_range(0, 99) >= 16);
                end
            end
        end
    end

    // Sender: reset, directed strings, then random strings.
    initial begin
        t_text q;
        sb           = new();
        chars_sent   = 0;
        strings_sent = 0;
        quiet_sender = 1'b0;
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_char_code <= '0;
        i_is_last   <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Field extremes and every named corner of both checkers.
        send_str("255.255.255.255");
        send_str("0.0.0.0");
        send_str("256.1.1.1");           // value over 255
        send_str("01.1.1.1");            // leading zero
        send_str("1.2.3");               // too few fields
        send_str("1.2.3.4.5");           // too many dots
        send_str("1..2.3");              // empty field
        send_str(".1.2.3");              // separator first
        send_str("1.2.3.");              // empty final field
        send_str("1234.1.1.1");          // field too long
        send_str("0:0:0:0:0:0:0:0");
        send_str("FFFF:ffff:AbCd:0123:1:2:3:4");
        send_str("12345:0:0:0:0:0:0:0"); // hex field too long
        send_str("1::2:3:4:5:6:7");      // compressed form
        send_str("1:2:3:4:5:6:7:8:9");   // ninth field
        send_str("1:2:3:4:5:6:7:");      // empty final field
        send_str("g:0:0:0:0:0:0:0");     // foreign letter
        send_str("1.2.3.4\377");         // high byte
        q = '{8'h00};
        send_text(q);
        send_str("7");
        send_str("1.2.3.4:");
        drain();

        strings_sent = 0;
        while (chars_sent < 1100) begin
            quiet_sender = (strings_sent >= 40 && strings_sent < 70);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: q = make_quad($urandom_range(0, 9) == 0);
                4, 5, 6, 7: q = make_colon();
                default:    q = make_noise();
            endcase
            if ($urandom_range(0, 9) < 4)
                mutate_text(q);
            send_text(q);
            if (strings_sent == 80)
                drain();
        end

        // Hold off until every class is back, then let the pipe settle.
        drain();
        repeat (10) @(posedge i_clk);
        if (sb.fail_count == 0) begin
            $display("[ip_address_text_classifier] OK");
        end else begin
            $display("[ip_address_text_classifier] ERROR");
        end
        $finish;
    end
endmodule

### filelist.f
+incdir+hdl
hdl/ipatc_pkg.sv
hdl/ipatc_fifo.sv
hdl/ipatc_front.sv
hdl/ipatc_back.sv
hdl/ip_address_text_classifier.sv
sim/tb_ip_address_text_classifier.sv
